// ===== hdl/sbms_pkg.sv =====
// shared types and codes for the shared-buffer multi-stack block
package sbms_pkg;

    typedef logic [1:0]  mode_t;
    typedef logic [1:0]  sel_t;
    typedef logic [31:0] word_t;
    typedef logic [1:0]  status_t;

    localparam mode_t MODE_PUSH = 2'd0;
    localparam mode_t MODE_POP  = 2'd1;
    localparam mode_t MODE_TOP  = 2'd2;
    localparam mode_t MODE_NOP  = 2'd3;

    localparam status_t STATUS_OK        = 2'd0;
    localparam status_t STATUS_BAD_STACK = 2'd1;
    localparam status_t STATUS_FULL      = 2'd2;
    localparam status_t STATUS_EMPTY     = 2'd3;

    localparam word_t FAIL_VALUE = 32'hFFFF_FFFF;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } sbms_state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic commit;
    } sbms_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic slot_free;
    } sbms_stat_t;

endpackage

// ===== hdl/sbms_req_if.sv =====
// request channel: operation, stack number and push value
interface sbms_req_if;
    import sbms_pkg::*;

    logic  valid;
    logic  ready;
    mode_t mode;
    sel_t  stack_sel;
    word_t push_value;

    modport source (output valid, output mode, output stack_sel, output push_value,
                    input ready);
    modport sink   (input valid, input mode, input stack_sel, input push_value,
                    output ready);
endinterface

// ===== hdl/sbms_rsp_if.sv =====
// response channel: status and read value
interface sbms_rsp_if;
    import sbms_pkg::*;

    logic    valid;
    logic    ready;
    status_t status;
    word_t   read_value;

    modport source (output valid, output status, output read_value, input ready);
    modport sink   (input valid, input status, input read_value, output ready);
endinterface

// ===== hdl/sbms_ram.sv =====
// generic single-write, single-read ram with registered read data
module sbms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

// ===== hdl/sbms_ctrl.sv =====
// controller: request accept and commit sequencing
module sbms_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  sbms_pkg::sbms_stat_t stat,
    output sbms_pkg::sbms_cmd_t  cmd
);
    import sbms_pkg::*;

    sbms_state_t state_reg;
    sbms_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        req_ready  = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                // hold until the previous response has left the output register
                if (stat.slot_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_load_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == ST_EXEC)
        else $error("load not followed by exec");
    a_commit_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> stat.slot_free && state_reg == ST_EXEC)
        else $error("commit without free output slot");
    a_no_double_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> !cmd.load)
        else $error("back to back load");
endmodule

// ===== hdl/sbms_datapath.sv =====
// datapath: stack heads, free list, link and value memories, output register
module sbms_datapath #(
    parameter int NODE_COUNT  = 128,
    parameter int STACK_COUNT = 3
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  sbms_pkg::sbms_cmd_t   cmd,
    output sbms_pkg::sbms_stat_t  stat,
    input  sbms_pkg::mode_t       req_mode,
    input  sbms_pkg::sel_t        req_stack_sel,
    input  sbms_pkg::word_t       req_push_value,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output sbms_pkg::status_t     rsp_status,
    output sbms_pkg::word_t       rsp_read_value
);
    import sbms_pkg::*;

    localparam int PW = $clog2(NODE_COUNT + 1);
    localparam int AW = $clog2(NODE_COUNT);
    // null link is the node count itself, never a node index
    localparam logic [PW-1:0] LINK_NULL = PW'(NODE_COUNT);

    mode_t   mode_reg;
    sel_t    sel_reg;
    word_t   value_reg;

    logic [PW-1:0] head_reg [STACK_COUNT];
    logic [PW-1:0] head_next [STACK_COUNT];
    logic [PW-1:0] free_head_reg;
    logic [PW-1:0] free_head_next;
    // nodes at or above this mark were never allocated, so their link is implicit
    logic [PW-1:0] fill_reg;
    logic [PW-1:0] fill_next;

    logic    out_valid_reg;
    logic    out_valid_next;
    status_t out_status_reg;
    word_t   out_value_reg;
    status_t status_next;
    word_t   read_value_next;

    logic [PW-1:0] head_in;
    logic [PW-1:0] head_cur;
    logic          bad_sel;
    logic          push_ok;
    logic          pop_ok;

    logic          val_wr_en;
    logic          link_wr_en;
    logic [AW-1:0] link_wr_addr;
    logic [PW-1:0] link_wr_data;
    logic [AW-1:0] link_rd_addr;
    logic [PW-1:0] link_rd_data;
    word_t         val_rd_data;

    // head of the stack named by the incoming request and by the held request
    always_comb
    begin
        head_in  = LINK_NULL;
        head_cur = LINK_NULL;
        for (int i = 0; i < STACK_COUNT; i++)
        begin
            if (int'(req_stack_sel) == i)
            begin
                head_in = head_reg[i];
            end
            if (int'(sel_reg) == i)
            begin
                head_cur = head_reg[i];
            end
        end
    end

    assign link_rd_addr = (req_mode == MODE_PUSH) ? free_head_reg[AW-1:0] : head_in[AW-1:0];

    assign bad_sel = int'(sel_reg) >= STACK_COUNT;

    always_comb
    begin
        status_next     = STATUS_OK;
        read_value_next = FAIL_VALUE;
        push_ok         = 1'b0;
        pop_ok          = 1'b0;
        if (mode_reg == MODE_NOP)
        begin
            status_next = STATUS_OK;
        end
        else if (bad_sel)
        begin
            status_next = STATUS_BAD_STACK;
        end
        else if (mode_reg == MODE_PUSH)
        begin
            if (free_head_reg == LINK_NULL)
            begin
                status_next = STATUS_FULL;
            end
            else
            begin
                push_ok = 1'b1;
            end
        end
        else if (head_cur == LINK_NULL)
        begin
            status_next = STATUS_EMPTY;
        end
        else
        begin
            read_value_next = val_rd_data;
            pop_ok          = (mode_reg == MODE_POP);
        end
    end

    always_comb
    begin
        free_head_next = free_head_reg;
        fill_next      = fill_reg;
        link_wr_en     = 1'b0;
        link_wr_addr   = free_head_reg[AW-1:0];
        link_wr_data   = head_cur;
        val_wr_en      = 1'b0;
        for (int i = 0; i < STACK_COUNT; i++)
        begin
            head_next[i] = head_reg[i];
        end
        if (cmd.commit && push_ok)
        begin
            val_wr_en  = 1'b1;
            link_wr_en = 1'b1;
            if (free_head_reg == fill_reg)
            begin
                // fresh node: its successor is the next fresh one, or null at the end
                free_head_next = fill_reg + PW'(1);
                fill_next      = fill_reg + PW'(1);
            end
            else
            begin
                free_head_next = link_rd_data;
            end
            for (int i = 0; i < STACK_COUNT; i++)
            begin
                if (int'(sel_reg) == i)
                begin
                    head_next[i] = free_head_reg;
                end
            end
        end
        else if (cmd.commit && pop_ok)
        begin
            link_wr_en     = 1'b1;
            link_wr_addr   = head_cur[AW-1:0];
            link_wr_data   = free_head_reg;
            free_head_next = head_cur;
            for (int i = 0; i < STACK_COUNT; i++)
            begin
                if (int'(sel_reg) == i)
                begin
                    head_next[i] = link_rd_data;
                end
            end
        end
    end

    assign stat.slot_free = !out_valid_reg || rsp_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < STACK_COUNT; i++)
            begin
                head_reg[i] <= LINK_NULL;
            end
            free_head_reg <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            for (int i = 0; i < STACK_COUNT; i++)
            begin
                head_reg[i] <= head_next[i];
            end
            free_head_reg <= free_head_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg  <= req_mode;
            sel_reg   <= req_stack_sel;
            value_reg <= req_push_value;
        end
        if (cmd.commit)
        begin
            out_status_reg <= status_next;
            out_value_reg  <= read_value_next;
        end
    end

    sbms_ram #(
        .WIDTH (PW),
        .DEPTH (NODE_COUNT)
    ) u_link_ram (
        .clk     (clk),
        .wr_en   (link_wr_en),
        .wr_addr (link_wr_addr),
        .wr_data (link_wr_data),
        .rd_en   (cmd.load),
        .rd_addr (link_rd_addr),
        .rd_data (link_rd_data)
    );

    sbms_ram #(
        .WIDTH ($bits(word_t)),
        .DEPTH (NODE_COUNT)
    ) u_value_ram (
        .clk     (clk),
        .wr_en   (val_wr_en),
        .wr_addr (free_head_reg[AW-1:0]),
        .wr_data (value_reg),
        .rd_en   (cmd.load),
        .rd_addr (head_in[AW-1:0]),
        .rd_data (val_rd_data)
    );

    assign rsp_valid      = out_valid_reg;
    assign rsp_status     = out_status_reg;
    assign rsp_read_value = out_value_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= LINK_NULL)
        else $error("fill mark past node count");
    a_free_head_allocated: assert property (@(posedge clk) disable iff (!rst_n)
        free_head_reg <= fill_reg || free_head_reg == LINK_NULL)
        else $error("free head beyond fresh node mark");
    a_push_links_head: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit && push_ok |=> head_cur == $past(free_head_reg))
        else $error("push did not move node to stack top");
    a_rsp_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.commit))
        else $error("response without commit");
endmodule

// ===== hdl/shared_buffer_multi_stack_core.sv =====
// Several LIFO stacks share one store of NODE_COUNT nodes linked through next
// pointers, with the unused nodes on a free list. A request names a stack and
// an operation (push, pop, read top) and yields exactly one response with a
// status and a value. A request is loaded in the idle state, where the link and
// value memories start a registered read; the exec state then commits the new
// links and loads the output register. The response sits in an output
// register, so the next request is accepted while it waits; a commit holds
// only while an earlier response has not been taken. Nodes never yet allocated
// are tracked by a fill mark, so no clearing pass runs after reset and the
// block takes requests from the first cycle.
module shared_buffer_multi_stack_core #(
    parameter int NODE_COUNT  = 128,
    parameter int STACK_COUNT = 3
) (
    input logic     clk,
    input logic     rst_n,
    sbms_req_if.sink   req,
    sbms_rsp_if.source rsp
);
    import sbms_pkg::*;

    sbms_cmd_t  cmd;
    sbms_stat_t stat;
    logic       req_ready;

    sbms_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    sbms_datapath #(
        .NODE_COUNT  (NODE_COUNT),
        .STACK_COUNT (STACK_COUNT)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .req_mode       (req.mode),
        .req_stack_sel  (req.stack_sel),
        .req_push_value (req.push_value),
        .rsp_valid      (rsp.valid),
        .rsp_ready      (rsp.ready),
        .rsp_status     (rsp.status),
        .rsp_read_value (rsp.read_value)
    );

    assign req.ready = req_ready;
endmodule

// ===== verif/shared_buffer_multi_stack_core_test.sv =====
// testbench for the shared-buffer multi-stack core: random push/pop/top traffic with checking
typedef struct {
    sbms_pkg::status_t status;
    sbms_pkg::word_t   value;
} stack_reply_t;

class stack_mirror #(int NODES = 128, int STACKS = 3);
    localparam int NIL = -1;

    sbms_pkg::word_t node_word[NODES];
    int              node_link[NODES];
    int              stack_top[STACKS];
    int              free_top;
    stack_reply_t    owed_replies[$];
    int              errors;

    function new();
        for (int i = 0; i < NODES; i++)
        begin
            node_word[i] = '0;
            node_link[i] = (i + 1 < NODES) ? i + 1 : NIL;
        end
        for (int s = 0; s < STACKS; s++)
        begin
            stack_top[s] = NIL;
        end
        free_top = 0;
        errors   = 0;
    endfunction

    task report_mismatch(string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    function int pending();
        return owed_replies.size();
    endfunction

    // apply one accepted request to the mirror and queue the reply it owes
    function void take_request(sbms_pkg::mode_t mode, sbms_pkg::sel_t sel,
                               sbms_pkg::word_t push_value);
        stack_reply_t r;
        int           n;
        r.status = sbms_pkg::STATUS_OK;
        r.value  = sbms_pkg::FAIL_VALUE;
        if (mode == sbms_pkg::MODE_NOP)
        begin
            // no operation
        end
        else if (int'(sel) >= STACKS)
        begin
            r.status = sbms_pkg::STATUS_BAD_STACK;
        end
        else if (mode == sbms_pkg::MODE_PUSH)
        begin
            n = free_top;
            if (n == NIL)
            begin
                r.status = sbms_pkg::STATUS_FULL;
            end
            else
            begin
                free_top       = node_link[n];
                node_word[n]   = push_value;
                node_link[n]   = stack_top[sel];
                stack_top[sel] = n;
            end
        end
        else
        begin
            n = stack_top[sel];
            if (n == NIL)
            begin
                r.status = sbms_pkg::STATUS_EMPTY;
            end
            else
            begin
                r.value = node_word[n];
                if (mode == sbms_pkg::MODE_POP)
                begin
                    stack_top[sel] = node_link[n];
                    node_link[n]   = free_top;
                    free_top       = n;
                end
            end
        end
        owed_replies.push_back(r);
    endfunction

    task check_response(sbms_pkg::status_t status, sbms_pkg::word_t value);
        stack_reply_t want;
        if (owed_replies.size() == 0)
        begin
            report_mismatch($sformatf("response %0d/%h with none outstanding", status, value));
        end
        else
        begin
            want = owed_replies.pop_front();
            if (status !== want.status)
                report_mismatch($sformatf("status %0d, wanted %0d", status, want.status));
            if (value !== want.value)
                report_mismatch($sformatf("read_value %h, wanted %h", value, want.value));
        end
    endtask
endclass

module shared_buffer_multi_stack_core_test;
    import sbms_pkg::*;

    localparam int NODE_COUNT  = 128;
    localparam int STACK_COUNT = 3;
    localparam int IDLE_LIMIT  = 5000;

    logic clk;
    logic rst_n;
    logic calm;
    int   idle_cycles;
    int   stall_left;

    stack_mirror #(NODE_COUNT, STACK_COUNT) sb;

    sbms_req_if req_ch ();
    sbms_rsp_if rsp_ch ();

    shared_buffer_multi_stack_core #(
        .NODE_COUNT  (NODE_COUNT),
        .STACK_COUNT (STACK_COUNT)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #1 clk = ~clk;

    // mostly short gaps, now and then a long one
    function int pick_gap();
        int r;
        r = $urandom_range(99);
        if (calm)
            return 0;
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    function word_t pick_value();
        case ($urandom_range(7))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h7FFF_FFFF;
            3: return 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    task send_request(mode_t mode, sel_t sel, word_t value);
        req_ch.valid      <= 1'b1;
        req_ch.mode       <= mode;
        req_ch.stack_sel  <= sel;
        req_ch.push_value <= value;
        do
            @(posedge clk);
        while (!req_ch.ready);
        sb.take_request(mode, sel, value);
    endtask

    task idle_sender();
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task run_phase(int count, int push_w, int pop_w);
        int    r;
        mode_t mode;
        sel_t  sel;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(99);
            if (r < 3)
                mode = MODE_NOP;
            else if (r < 3 + push_w)
                mode = MODE_PUSH;
            else if (r < 3 + push_w + pop_w)
                mode = MODE_POP;
            else
                mode = MODE_TOP;
            sel = ($urandom_range(99) < 5) ? sel_t'(3) : sel_t'($urandom_range(STACK_COUNT - 1));
            send_request(mode, sel, pick_value());
            idle_sender();
        end
    endtask

    // response side: random back-pressure
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            rsp_ch.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end
        else
        begin
            rsp_ch.ready <= 1'b1;
            if ($urandom_range(99) < 25)
                stall_left <= pick_gap();
        end
    end

    always @(posedge clk)
    begin
        if (rsp_ch.valid && rsp_ch.ready)
            sb.check_response(rsp_ch.status, rsp_ch.read_value);
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        sb                = new();
        clk               = 1'b0;
        rst_n             = 1'b0;
        calm              = 1'b0;
        idle_cycles       = 0;
        stall_left        = 0;
        req_ch.valid      = 1'b0;
        req_ch.mode       = MODE_NOP;
        req_ch.stack_sel  = '0;
        req_ch.push_value = '0;
        rsp_ch.ready      = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty stacks, bad stack numbers, unused mode
        send_request(MODE_POP,  2'd0, 32'h0);
        send_request(MODE_TOP,  2'd1, 32'h0);
        send_request(MODE_PUSH, 2'd3, 32'h1234_5678);
        send_request(MODE_POP,  2'd3, 32'h0);
        send_request(MODE_TOP,  2'd3, 32'h0);
        send_request(MODE_NOP,  2'd3, 32'hFFFF_FFFF);
        send_request(MODE_NOP,  2'd0, 32'h0);
        // value extremes across all stacks
        send_request(MODE_PUSH, 2'd0, 32'h7FFF_FFFF);
        send_request(MODE_PUSH, 2'd1, 32'h8000_0000);
        send_request(MODE_PUSH, 2'd2, 32'hFFFF_FFFF);
        send_request(MODE_PUSH, 2'd0, 32'h0000_0000);
        send_request(MODE_PUSH, 2'd1, 32'hA5A5_5A5A);
        send_request(MODE_TOP,  2'd0, 32'h0);
        send_request(MODE_POP,  2'd0, 32'h0);
        send_request(MODE_TOP,  2'd0, 32'h0);
        send_request(MODE_POP,  2'd1, 32'h0);
        send_request(MODE_POP,  2'd1, 32'h0);
        send_request(MODE_POP,  2'd1, 32'h0);
        send_request(MODE_POP,  2'd2, 32'h0);
        send_request(MODE_PUSH, 2'd2, 32'h5A5A_A5A5);
        idle_sender();

        // fill phases push the store to full, drain phases run stacks empty
        run_phase(200, 85, 8);
        run_phase(200, 15, 70);
        run_phase(200, 85, 8);

        // hold off until every outstanding response is back
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);

        calm = 1'b1;
        run_phase(200, 40, 35);
        calm = 1'b0;
        run_phase(200, 15, 70);
        run_phase(200, 45, 35);

        req_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

// ===== files.f =====
hdl/sbms_pkg.sv
hdl/sbms_req_if.sv
hdl/sbms_rsp_if.sv
hdl/sbms_ram.sv
hdl/sbms_ctrl.sv
hdl/sbms_datapath.sv
hdl/shared_buffer_multi_stack_core.sv
verif/shared_buffer_multi_stack_core_test.sv
